// ===== rtl/mcms_pkg.sv =====
// ----------------------------------------------------------------------------
// Median common-mode subtractor package
// Shared sizes, the controller state type and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mcms_pkg;

  // Largest strip group and amplitude width.
  localparam int unsigned GROUP_MAX   = 32;
  localparam int unsigned SAMPLE_BITS = 14;
  localparam int unsigned OUT_BITS    = SAMPLE_BITS + 1;

  // Index into a group, and a count that can hold the full group size.
  localparam int unsigned IDX_W = $clog2(GROUP_MAX);
  localparam int unsigned CNT_W = $clog2(GROUP_MAX + 1);

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MEDIAN,
    ST_EMIT
  } mcms_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // store the incoming amplitude
    logic latch_median;  // capture the middle element of the sorted chain
    logic emit_en;       // allow buffer reads towards the output
    logic clear_group;   // group finished, restart the fill count
  } mcms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full_next;  // the next stored strip fills the buffer
    logic drained;    // every buffered strip has left the read stage
  } mcms_status_t;

endpackage

// ===== rtl/mcms_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module mcms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mcms_ctrl.sv =====
// ----------------------------------------------------------------------------
// Median common-mode subtractor controller
// Sequences loading of a strip group, capture of its median and the
// emission of the corrected amplitudes.
// ----------------------------------------------------------------------------
module mcms_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  mcms_pkg::mcms_status_t status_i,
  output mcms_pkg::mcms_cmd_t    cmd_o
);
  import mcms_pkg::*;

  mcms_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    in_ready_o         = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // A marked last strip or a full buffer closes the group.
          if (in_last_i || status_i.full_next) begin
            state_d = ST_MEDIAN;
          end
        end
      end
      ST_MEDIAN: begin
        cmd_o.latch_median = 1'b1;
        state_d            = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (status_i.drained) begin
          cmd_o.clear_group = 1'b1;
          state_d           = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/mcms_datapath.sv =====
// ----------------------------------------------------------------------------
// Median common-mode subtractor datapath
// Arrival-order sample buffer, a sorted insertion chain, the median
// register, the buffer read stage and the output register.
// ----------------------------------------------------------------------------
module mcms_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcms_pkg::mcms_cmd_t                 cmd_i,
  output mcms_pkg::mcms_status_t              status_o,
  input  logic signed [mcms_pkg::SAMPLE_BITS-1:0] amplitude_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mcms_pkg::OUT_BITS-1:0]    corrected_o,
  output logic                                final_of_group_o
);
  import mcms_pkg::*;

  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]              half_count;
  logic signed [SAMPLE_BITS-1:0] chain_q [GROUP_MAX];
  logic signed [SAMPLE_BITS-1:0] chain_d [GROUP_MAX];
  logic [GROUP_MAX-1:0]          above;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic                          rd_vld_q, rd_vld_d;
  logic                          rd_last_q;
  logic                          rd_issue;
  logic                          advance;
  logic                          out_vld_q, out_vld_d;
  logic signed [OUT_BITS-1:0]    out_data_q;
  logic                          out_last_q;
  logic signed [OUT_BITS-1:0]    diff;

  // Arrival-order buffer: written while loading, read during emission.
  mcms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (GROUP_MAX)
  ) u_sample_buffer (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (amplitude_i),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // Sorted chain insertion. Cells at or beyond the fill count act as
  // empty slots that hold a value larger than any amplitude. Each cell
  // keeps its value, takes the new amplitude, or takes its lower
  // neighbour's value when the chain shifts up.
  always_comb begin
    for (int i = 0; i < GROUP_MAX; i++) begin
      above[i] = (CNT_W'(i) >= count_q) || (chain_q[i] > amplitude_i);
    end
    for (int i = 0; i < GROUP_MAX; i++) begin
      if (!above[i]) begin
        chain_d[i] = chain_q[i];
      end else if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
        chain_d[i] = chain_q[(i > 0) ? i - 1 : 0];
      end else begin
        chain_d[i] = amplitude_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < GROUP_MAX; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

  // Median capture: the element at index count/2 of the sorted chain.
  assign half_count = count_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_median) begin
      median_q <= chain_q[half_count[IDX_W-1:0]];
    end
  end

  // Read stage and output register handshake.
  assign advance  = rd_vld_q && (!out_vld_q || out_ready_i);
  assign rd_issue = cmd_i.emit_en && (rd_idx_q != count_q) && (!rd_vld_q || advance);

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (rd_issue) begin
      rd_vld_d = 1'b1;
    end else if (advance) begin
      rd_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Fill count and read index.
  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.clear_group) begin
      count_d  = '0;
      rd_idx_d = '0;
    end else begin
      if (cmd_i.load) begin
        count_d = count_q + CNT_W'(1);
      end
      if (rd_issue) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // The last-of-group flag travels with the read data.
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_last_q <= (rd_idx_q == count_q - CNT_W'(1));
    end
  end

  // Subtract the median at one bit wider so the difference always fits.
  assign diff = $signed({rd_data[SAMPLE_BITS-1], rd_data})
              - $signed({median_q[SAMPLE_BITS-1], median_q});

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= diff;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign corrected_o      = out_data_q;
  assign final_of_group_o = out_last_q;

  // Status towards the controller.
  assign status_o.full_next = (count_q == CNT_W'(GROUP_MAX - 1));
  assign status_o.drained   = (rd_idx_q == count_q) && !rd_vld_q;

  // The fill count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(GROUP_MAX))
    else $error("fill count beyond buffer depth");

  // Reads never run ahead of the strips stored.
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= count_q)
    else $error("read index beyond fill count");

  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.emit_en))
    else $error("load during emission");

  // The two lowest filled cells of the chain are in ascending order.
  a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (chain_q[0] <= chain_q[1]))
    else $error("sorted chain out of order");

endmodule

// ===== rtl/median_common_mode_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// Median common-mode subtractor core
// Flow: each strip transfer is written to the buffer and the sorted chain;
// the transfer that closes the group is followed by median capture, then
// each strip passes the buffer read register and the output register, one
// result per cycle while the output is taken; each is read back once.
// Reset: asynchronous, active low; clears the fill count and all handshakes.
// ----------------------------------------------------------------------------
// Median common-mode subtractor top level
// Buffers a strip group, finds its median and streams out every amplitude
// minus that median in arrival order.
// ----------------------------------------------------------------------------
module median_common_mode_subtractor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mcms_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [13:0] amplitude
  input  logic                                s_axis_tlast_i,   // group_end
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mcms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // [14:0] corrected
  output logic                                m_axis_tlast_o    // final_of_group
);
  import mcms_pkg::*;

  mcms_cmd_t                  cmd;
  mcms_status_t               status;
  logic signed [OUT_BITS-1:0] corrected;

  // Sequencing of load, median capture and emission.
  mcms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage, sorting and subtraction.
  mcms_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .amplitude_i      ($signed(s_axis_tdata_i[SAMPLE_BITS-1:0])),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .corrected_o      (corrected),
    .final_of_group_o (m_axis_tlast_o)
  );

  // Zero padding of the result up to whole bytes.
  assign m_axis_tdata_o = OUT_TDATA_W'($unsigned(corrected));

endmodule
